/* sv/adcvm_pkg.sv */
package adcvm_pkg;

    // converter and display size
    localparam int ADC_BITS    = 12;
    localparam int DIGITS      = 4;

    // register widths
    localparam int SCALE_BITS  = 18;
    localparam int PERIOD_BITS = 16;
    localparam int DWELL_BITS  = 8;
    localparam int POINT_BITS  = 2;
    localparam int CFG_BITS    = 18;
    localparam int CFG_IDX_BITS = 2;

    // register reset values
    localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = SCALE_BITS'(70939);
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(300);
    localparam logic [DWELL_BITS-1:0]  DWELL_RESET  = DWELL_BITS'(1);
    localparam logic [POINT_BITS-1:0]  POINT_RESET  = POINT_BITS'(2);

    // Q2.16 scale: product drops 16 fraction bits
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = ADC_BITS + SCALE_BITS;
    localparam int CV_BITS    = PROD_BITS - FRAC_BITS;
    localparam longint unsigned MAX_VALUE = 64'(10 ** DIGITS) - 64'd1;
    localparam int VAL_BITS   = $clog2(10 ** DIGITS);
    localparam int CMP_BITS   = (CV_BITS > VAL_BITS) ? CV_BITS : VAL_BITS;
    localparam int QP_BITS    = 2 * VAL_BITS + 1;
    localparam int IDX_BITS   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int SEL_BITS   = 4;
    localparam int SEG_BITS   = 8;
    localparam int DIGIT_BITS = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SCALE  = 2'd0,
        CFG_PERIOD = 2'd1,
        CFG_DWELL  = 2'd2,
        CFG_POINT  = 2'd3
    } cfg_idx_t;

    typedef logic [DIGIT_BITS-1:0] digit_t;
    typedef logic [SEG_BITS-1:0]   seg_t;

    // active-low patterns, bit 7 is the decimal point
    localparam seg_t SEG_TABLE [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
        8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };
    localparam seg_t SEG_BLANK = 8'hFF;

endpackage

/* sv/adc_voltmeter_seven_segment_scan.sv */
// A transaction accepted at the input passes through the input, product, saturate, quotient
// and output registers in that order before its result shows at the output register.
// Throughput: one transaction per cycle while in_stall is low; scan and period counters update on acceptance.
// Reset (rst_n, async, active low): registers to their defaults, measurement due, all digits 0,
// scan position and counters 0, pipeline empty.
module adc_voltmeter_seven_segment_scan (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [adcvm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [adcvm_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [adcvm_pkg::ADC_BITS-1:0]         adc_sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [adcvm_pkg::SEG_BITS-1:0]         segments,
    output logic [adcvm_pkg::SEL_BITS-1:0]         digit_select
);
    import adcvm_pkg::*;

    // configuration
    logic [SCALE_BITS-1:0]  scale_reg;
    logic [PERIOD_BITS-1:0] period_reg;
    logic [DWELL_BITS-1:0]  dwell_reg;
    logic [POINT_BITS-1:0]  point_reg;

    // scan control state
    logic [PERIOD_BITS-1:0] period_count_reg, period_count_next;
    logic                   sample_due_reg, sample_due_next;
    logic [IDX_BITS-1:0]    scan_index_reg, scan_index_next;
    logic [DWELL_BITS-1:0]  dwell_count_reg, dwell_count_next;
    digit_t                 shown_reg [DIGITS];
    digit_t                 shown_next [DIGITS];

    // pipeline
    logic                   s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                   s1_cap_reg, s2_cap_reg, s3_cap_reg, s4_cap_reg;
    logic [IDX_BITS-1:0]    s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [ADC_BITS-1:0]    s1_sample_reg;
    logic [PROD_BITS-1:0]   s2_prod_reg;
    logic [VAL_BITS-1:0]    s3_value_reg;
    logic [VAL_BITS-1:0]    s4_quot_reg [DIGITS];
    logic                   out_valid_reg;
    seg_t                   segments_reg, segments_next;
    logic [SEL_BITS-1:0]    digit_select_reg, digit_select_next;

    logic en1, en2, en3, en4, en5;
    logic accept;
    logic cap_now;

    logic [PERIOD_BITS-1:0] period_eff;
    logic [DWELL_BITS-1:0]  dwell_eff;
    logic [PERIOD_BITS-1:0] pc_inc;
    logic [DWELL_BITS:0]    dc_inc;

    logic [CV_BITS-1:0]     cv;
    logic [CMP_BITS-1:0]    cv_ext;
    logic [VAL_BITS-1:0]    sat_value;
    logic [VAL_BITS-1:0]    quot [DIGITS];
    digit_t                 new_digit [DIGITS];
    digit_t                 cur_digit;

    // each stage loads when empty or when the next one moves
    assign en5      = !out_valid_reg || !out_stall;
    assign en4      = !s4_valid_reg || en5;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;
    assign accept   = in_valid && en1;

    assign out_valid    = out_valid_reg;
    assign segments     = segments_reg;
    assign digit_select = digit_select_reg;

    // ---- scan and period counters, advanced per accepted tick ----
    always_comb
    begin
        period_eff = (period_reg == '0) ? PERIOD_BITS'(1) : period_reg;
        dwell_eff  = (dwell_reg == '0) ? DWELL_BITS'(1) : dwell_reg;
        cap_now    = (scan_index_reg == '0) && (dwell_count_reg == '0) && sample_due_reg;

        dc_inc = {1'b0, dwell_count_reg} + (DWELL_BITS + 1)'(1);
        if (dc_inc >= {1'b0, dwell_eff})
        begin
            dwell_count_next = '0;
            if (scan_index_reg == IDX_BITS'(DIGITS - 1))
                scan_index_next = '0;
            else
                scan_index_next = scan_index_reg + IDX_BITS'(1);
        end
        else
        begin
            dwell_count_next = dc_inc[DWELL_BITS-1:0];
            scan_index_next  = scan_index_reg;
        end

        sample_due_next = cap_now ? 1'b0 : sample_due_reg;
        pc_inc = period_count_reg + PERIOD_BITS'(1);
        if (pc_inc >= period_eff || pc_inc == '0)
        begin
            period_count_next = '0;
            sample_due_next   = 1'b1;
        end
        else
        begin
            period_count_next = pc_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg        <= SCALE_RESET;
            period_reg       <= PERIOD_RESET;
            dwell_reg        <= DWELL_RESET;
            point_reg        <= POINT_RESET;
            period_count_reg <= '0;
            sample_due_reg   <= 1'b1;
            scan_index_reg   <= '0;
            dwell_count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_SCALE:  scale_reg  <= cfg_data[SCALE_BITS-1:0];
                    CFG_PERIOD: period_reg <= cfg_data[PERIOD_BITS-1:0];
                    CFG_DWELL:  dwell_reg  <= cfg_data[DWELL_BITS-1:0];
                    CFG_POINT:  point_reg  <= cfg_data[POINT_BITS-1:0];
                    default:    scale_reg  <= scale_reg;
                endcase
            end
            if (accept)
            begin
                period_count_reg <= period_count_next;
                sample_due_reg   <= sample_due_next;
                scan_index_reg   <= scan_index_next;
                dwell_count_reg  <= dwell_count_next;
            end
        end
    end

    // ---- datapath ----
    always_comb
    begin
        cv        = s2_prod_reg[PROD_BITS-1:FRAC_BITS];
        cv_ext    = CMP_BITS'(cv);
        sat_value = (cv_ext > CMP_BITS'(MAX_VALUE)) ? VAL_BITS'(MAX_VALUE)
                                                    : VAL_BITS'(cv_ext);
    end

    assign quot[0] = s3_value_reg;

    // floor(v / 10^k) by exact reciprocal multiply
    for (genvar k = 1; k < DIGITS; k++)
    begin : g_quot
        localparam longint unsigned POW = 64'(10 ** k);
        localparam int SH = VAL_BITS + $clog2(10 ** k);
        localparam longint unsigned MUL = ((64'd1 << SH) + POW - 64'd1) / POW;
        logic [QP_BITS-1:0] qprod;
        assign qprod   = QP_BITS'(s3_value_reg) * QP_BITS'(MUL);
        assign quot[k] = VAL_BITS'(qprod >> SH);
    end

    always_comb
    begin
        for (int k = 0; k < DIGITS - 1; k++)
            new_digit[k] = DIGIT_BITS'(s4_quot_reg[k]
                                       - (s4_quot_reg[k+1] << 3)
                                       - (s4_quot_reg[k+1] << 1));
        new_digit[DIGITS-1] = DIGIT_BITS'(s4_quot_reg[DIGITS-1]);
        for (int k = 0; k < DIGITS; k++)
            shown_next[k] = s4_cap_reg ? new_digit[k] : shown_reg[k];

        cur_digit = shown_next[s4_idx_reg];
        if (cur_digit < DIGIT_BITS'(10))
            segments_next = SEG_TABLE[cur_digit];
        else
            segments_next = SEG_BLANK;
        if (32'(s4_idx_reg) == 32'(point_reg))
            segments_next[SEG_BITS-1] = 1'b0;

        for (int b = 0; b < SEL_BITS; b++)
            digit_select_next[b] = (32'(s4_idx_reg) == b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < DIGITS; k++)
                shown_reg[k] <= '0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= in_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (en4)
                s4_valid_reg <= s3_valid_reg;
            if (en5)
                out_valid_reg <= s4_valid_reg;
            if (en5 && s4_valid_reg && s4_cap_reg)
            begin
                for (int k = 0; k < DIGITS; k++)
                    shown_reg[k] <= new_digit[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= adc_sample;
            s1_cap_reg    <= cap_now;
            s1_idx_reg    <= scan_index_reg;
        end
        if (en2 && s1_valid_reg)
        begin
            s2_prod_reg <= PROD_BITS'(s1_sample_reg) * PROD_BITS'(scale_reg);
            s2_cap_reg  <= s1_cap_reg;
            s2_idx_reg  <= s1_idx_reg;
        end
        if (en3 && s2_valid_reg)
        begin
            s3_value_reg <= sat_value;
            s3_cap_reg   <= s2_cap_reg;
            s3_idx_reg   <= s2_idx_reg;
        end
        if (en4 && s3_valid_reg)
        begin
            for (int k = 0; k < DIGITS; k++)
                s4_quot_reg[k] <= quot[k];
            s4_cap_reg <= s3_cap_reg;
            s4_idx_reg <= s3_idx_reg;
        end
        if (en5 && s4_valid_reg)
        begin
            segments_reg     <= segments_next;
            digit_select_reg <= digit_select_next;
        end
    end

    // a capture only ever starts a scan
    a_cap_at_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_cap_reg |-> s1_idx_reg == '0)
        else $error("capture outside scan start");

    a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(digit_select))
        else $error("digit select not one-hot");

    // input held off only when the first stage is occupied and blocked
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg
                     && out_valid_reg && out_stall)
        else $error("input stalled with room in pipeline");

    // capture clears the due flag unless the period wraps in the same tick
    a_due_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cap_now && period_count_next != '0 |=> !sample_due_reg)
        else $error("measurement still due after capture");

endmodule
